>>> rtl/tbga_pkg.sv
// Types, widths, latencies and helper functions of the three-body acceleration pipeline.
// Standalone: no dependencies. Used by every module under rtl/.
package tbga_pkg;

	localparam int POS_W = 40;
	localparam int DIF_W = POS_W + 1;
	localparam int GM_W = 60;
	localparam int ACC_W = 48;
	localparam int SQ_W = 42;
	localparam int D2_W = 2 * DIF_W;
	localparam int DEN_W = D2_W + SQ_W;
	localparam int NP_W = GM_W + SQ_W;
	localparam int NUM_SHIFT = 40;
	localparam int NUM_W = NP_W + NUM_SHIFT;
	localparam int QB_W = 48;
	localparam int Q_W = QB_W + 1;
	localparam int SH_W = DEN_W + QB_W;
	localparam int SAT_SH = QB_W - NUM_SHIFT;
	localparam int CFG_IDX_W = 2;

	localparam int MUL_DIG = 7;
	localparam int MUL_LAT = (SQ_W + MUL_DIG - 1) / MUL_DIG;
	localparam int ISQ_LAT = SQ_W;
	localparam int DIV_LAT = QB_W + 1;
	localparam int MAG_DLY = MUL_LAT + 1 + ISQ_LAT;
	localparam int ZERO_DLY = 1 + ISQ_LAT + MUL_LAT + DIV_LAT;
	localparam int SIGN_DLY = MAG_DLY + MUL_LAT + DIV_LAT;
	localparam int LANE_LAT = 1 + MAG_DLY + MUL_LAT + DIV_LAT;

	localparam logic [GM_W-1:0] GM_ONE_RST = 60'd521093750000000000;
	localparam logic [GM_W-1:0] GM_TWO_RST = 60'd166750000000;
	localparam logic [GM_W-1:0] GM_THREE_RST = 60'd2866;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GM_ONE = 2'd0,
		CFG_GM_TWO = 2'd1,
		CFG_GM_THREE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x_one;
		logic signed [POS_W-1:0] pos_y_one;
		logic signed [POS_W-1:0] pos_x_two;
		logic signed [POS_W-1:0] pos_y_two;
		logic signed [POS_W-1:0] pos_x_three;
		logic signed [POS_W-1:0] pos_y_three;
	} pos_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc_x_one;
		logic signed [ACC_W-1:0] acc_y_one;
		logic signed [ACC_W-1:0] acc_x_two;
		logic signed [ACC_W-1:0] acc_y_two;
		logic signed [ACC_W-1:0] acc_x_three;
		logic signed [ACC_W-1:0] acc_y_three;
		logic coincide_error;
	} acc_t;

	// per pair: a is the first body, b the second; neg_* is the sign of (b - a)
	typedef struct packed {
		logic coincide;
		logic neg_x;
		logic neg_y;
		logic [Q_W-1:0] a_x;
		logic [Q_W-1:0] a_y;
		logic [Q_W-1:0] b_x;
		logic [Q_W-1:0] b_y;
	} lane_t;

	function automatic logic [Q_W:0] signed_term(input logic neg, input logic [Q_W-1:0] mag);
		logic [Q_W:0] m;
		m = {1'b0, mag};
		return neg ? ((Q_W+1)'(0) - m) : m;
	endfunction

	function automatic logic [ACC_W-1:0] sat_sum(input logic [Q_W:0] ta, input logic [Q_W:0] tb);
		logic [Q_W+1:0] s;
		s = {ta[Q_W], ta} + {tb[Q_W], tb};
		if (s[Q_W+1:ACC_W-1] == '0 || s[Q_W+1:ACC_W-1] == '1) begin
			return s[ACC_W-1:0];
		end else if (s[Q_W+1]) begin
			return {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			return {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

endpackage

>>> rtl/three_body_gravity_acceleration.sv
// One input transfer per cycle while no result waits under acc_stall; results appear on acc.
// Depth comes mostly from the 42-stage square root and the 49-stage dividers in each pair lane.
// The whole pipeline holds while a result waits under acc_stall.
// arst_n clears the valid pipeline and loads the default GM values; data regs are not reset.
// Depends on tbga_pkg and tbga_lane.
module three_body_gravity_acceleration (
	input logic clk,
	input logic arst_n,
	input logic pos_valid,
	output logic pos_stall,
	input tbga_pkg::pos_t pos,
	output logic acc_valid,
	input logic acc_stall,
	output tbga_pkg::acc_t acc,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tbga_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tbga_pkg::GM_W-1:0] cfg_data
);
	localparam int LL = tbga_pkg::LANE_LAT;

	logic [tbga_pkg::GM_W-1:0] gm_one_q, gm_two_q, gm_three_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gm_one_q <= tbga_pkg::GM_ONE_RST;
			gm_two_q <= tbga_pkg::GM_TWO_RST;
			gm_three_q <= tbga_pkg::GM_THREE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (tbga_pkg::cfg_idx_t'(cfg_index))
				tbga_pkg::CFG_GM_ONE: gm_one_q <= cfg_data;
				tbga_pkg::CFG_GM_TWO: gm_two_q <= cfg_data;
				tbga_pkg::CFG_GM_THREE: gm_three_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	logic [LL:0] vld_q;
	tbga_pkg::pos_t pos_s0;
	tbga_pkg::acc_t acc_q;

	assign en = !out_valid_q || !acc_stall;
	assign pos_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LL-1:0], pos_valid};
			out_valid_q <= vld_q[LL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s0 <= pos;
		end
	end

	tbga_pkg::lane_t l12, l13, l23;

	tbga_lane u_l12 (
		.clk(clk), .en(en),
		.xa(pos_s0.pos_x_one), .ya(pos_s0.pos_y_one),
		.xb(pos_s0.pos_x_two), .yb(pos_s0.pos_y_two),
		.gm_a(gm_one_q), .gm_b(gm_two_q), .res(l12)
	);

	tbga_lane u_l13 (
		.clk(clk), .en(en),
		.xa(pos_s0.pos_x_one), .ya(pos_s0.pos_y_one),
		.xb(pos_s0.pos_x_three), .yb(pos_s0.pos_y_three),
		.gm_a(gm_one_q), .gm_b(gm_three_q), .res(l13)
	);

	tbga_lane u_l23 (
		.clk(clk), .en(en),
		.xa(pos_s0.pos_x_two), .ya(pos_s0.pos_y_two),
		.xb(pos_s0.pos_x_three), .yb(pos_s0.pos_y_three),
		.gm_a(gm_two_q), .gm_b(gm_three_q), .res(l23)
	);

	// merge: body one <- 12a + 13a, body two <- 12b + 23a, body three <- 13b + 23b
	tbga_pkg::acc_t merged;
	logic coincide;

	assign coincide = l12.coincide || l13.coincide || l23.coincide;

	always_comb begin
		merged.acc_x_one = tbga_pkg::sat_sum(tbga_pkg::signed_term(l12.neg_x, l12.a_x),
			tbga_pkg::signed_term(l13.neg_x, l13.a_x));
		merged.acc_y_one = tbga_pkg::sat_sum(tbga_pkg::signed_term(l12.neg_y, l12.a_y),
			tbga_pkg::signed_term(l13.neg_y, l13.a_y));
		merged.acc_x_two = tbga_pkg::sat_sum(tbga_pkg::signed_term(!l12.neg_x, l12.b_x),
			tbga_pkg::signed_term(l23.neg_x, l23.a_x));
		merged.acc_y_two = tbga_pkg::sat_sum(tbga_pkg::signed_term(!l12.neg_y, l12.b_y),
			tbga_pkg::signed_term(l23.neg_y, l23.a_y));
		merged.acc_x_three = tbga_pkg::sat_sum(tbga_pkg::signed_term(!l13.neg_x, l13.b_x),
			tbga_pkg::signed_term(!l23.neg_x, l23.b_x));
		merged.acc_y_three = tbga_pkg::sat_sum(tbga_pkg::signed_term(!l13.neg_y, l13.b_y),
			tbga_pkg::signed_term(!l23.neg_y, l23.b_y));
		merged.coincide_error = coincide;
		if (coincide) begin
			merged = '0;
			merged.coincide_error = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= merged;
		end
	end

	assign acc_valid = out_valid_q;
	assign acc = acc_q;

endmodule

>>> rtl/tbga_mul.sv
// Pipelined multiplier: WA-bit operand times a 42-bit operand, 7 bits of b per stage.
// Depends on tbga_pkg (SQ_W, MUL_DIG, MUL_LAT).
module tbga_mul #(
	parameter int WA = 41
) (
	input logic clk,
	input logic en,
	input logic [WA-1:0] a,
	input logic [tbga_pkg::SQ_W-1:0] b,
	output logic [WA+tbga_pkg::SQ_W-1:0] p
);
	localparam int WP = WA + tbga_pkg::SQ_W;
	localparam int DIG = tbga_pkg::MUL_DIG;
	localparam int NST = tbga_pkg::MUL_LAT;
	localparam int BW = NST * DIG;

	logic [WA-1:0] a_w [0:NST];
	logic [BW-1:0] b_w [0:NST];
	logic [WP-1:0] acc_w [0:NST];

	assign a_w[0] = a;
	assign b_w[0] = BW'(b);
	assign acc_w[0] = '0;

	for (genvar j = 0; j < NST; j++) begin : g_st
		logic [WA+DIG-1:0] pp;
		logic [WA-1:0] a_s;
		logic [BW-1:0] b_s;
		logic [WP-1:0] acc_s;

		assign pp = (WA+DIG)'(a_w[j]) * (WA+DIG)'(b_w[j][j*DIG +: DIG]);

		always_ff @(posedge clk) begin
			if (en) begin
				a_s <= a_w[j];
				b_s <= b_w[j];
				acc_s <= acc_w[j] + (WP'(pp) << (j * DIG));
			end
		end

		assign a_w[j+1] = a_s;
		assign b_w[j+1] = b_s;
		assign acc_w[j+1] = acc_s;
	end

	assign p = acc_w[NST];

endmodule

>>> rtl/tbga_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor(sqrt(d2)).
// Depends on tbga_pkg (D2_W, SQ_W). Passes d2 along for the next stage.
module tbga_isqrt (
	input logic clk,
	input logic en,
	input logic [tbga_pkg::D2_W-1:0] d2,
	output logic [tbga_pkg::SQ_W-1:0] root,
	output logic [tbga_pkg::D2_W-1:0] d2_out
);
	localparam int RW = tbga_pkg::D2_W;
	localparam int SW = tbga_pkg::SQ_W;
	localparam int TW = 2 * SW;

	logic [RW-1:0] rem_w [0:SW];
	logic [RW-1:0] d2_w [0:SW];
	logic [SW-1:0] r_w [0:SW];

	assign rem_w[0] = d2;
	assign d2_w[0] = d2;
	assign r_w[0] = '0;

	for (genvar i = 0; i < SW; i++) begin : g_st
		localparam int B = SW - 1 - i;
		logic [TW-1:0] trial;
		logic take;
		logic [RW-1:0] rem_s;
		logic [RW-1:0] d2_s;
		logic [SW-1:0] r_s;

		// (r + 2^B)^2 - r^2
		assign trial = (TW'(r_w[i]) << (B + 1)) | (TW'(1) << (2 * B));
		assign take = TW'(rem_w[i]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s <= take ? (rem_w[i] - RW'(trial)) : rem_w[i];
				r_s <= take ? (r_w[i] | (SW'(1) << B)) : r_w[i];
				d2_s <= d2_w[i];
			end
		end

		assign rem_w[i+1] = rem_s;
		assign r_w[i+1] = r_s;
		assign d2_w[i+1] = d2_s;
	end

	assign root = r_w[SW];
	assign d2_out = d2_w[SW];

endmodule

>>> rtl/tbga_div.sv
// Pipelined restoring divider: trunc(num_p * 2^40 / den), held at 2^48 on overflow.
// Depends on tbga_pkg. One saturation-check stage, then one quotient bit per stage.
module tbga_div (
	input logic clk,
	input logic en,
	input logic [tbga_pkg::NP_W-1:0] num_p,
	input logic [tbga_pkg::DEN_W-1:0] den,
	output logic [tbga_pkg::Q_W-1:0] q
);
	localparam int NW = tbga_pkg::NUM_W;
	localparam int DW = tbga_pkg::DEN_W;
	localparam int SW = tbga_pkg::SH_W;
	localparam int QW = tbga_pkg::QB_W;
	localparam int SS = tbga_pkg::SAT_SH;

	logic [NW-1:0] rem_s1;
	logic [DW-1:0] den_s1;
	logic sat_s1;

	// num * 2^40 >= den * 2^48  <=>  num >= den * 2^8
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= {num_p, {tbga_pkg::NUM_SHIFT{1'b0}}};
			den_s1 <= den;
			sat_s1 <= (DW+SS)'(num_p) >= {den, {SS{1'b0}}};
		end
	end

	logic [NW-1:0] rem_w [0:QW];
	logic [DW-1:0] den_w [0:QW];
	logic [QW-1:0] q_w [0:QW];
	logic sat_w [0:QW];

	assign rem_w[0] = rem_s1;
	assign den_w[0] = den_s1;
	assign q_w[0] = '0;
	assign sat_w[0] = sat_s1;

	for (genvar i = 0; i < QW; i++) begin : g_st
		localparam int K = QW - 1 - i;
		logic [SW-1:0] sh;
		logic take;
		logic [NW-1:0] rem_s;
		logic [DW-1:0] den_s;
		logic [QW-1:0] q_s;
		logic sat_s;

		assign sh = SW'(den_w[i]) << K;
		assign take = SW'(rem_w[i]) >= sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s <= take ? (rem_w[i] - NW'(sh)) : rem_w[i];
				q_s <= take ? (q_w[i] | (QW'(1) << K)) : q_w[i];
				den_s <= den_w[i];
				sat_s <= sat_w[i];
			end
		end

		assign rem_w[i+1] = rem_s;
		assign den_w[i+1] = den_s;
		assign q_w[i+1] = q_s;
		assign sat_w[i+1] = sat_s;
	end

	assign q = sat_w[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, q_w[QW]};

endmodule

>>> rtl/tbga_lane.sv
// One body pair: distance, square root, cube and the four force terms of the pair.
// Depends on tbga_pkg, tbga_mul, tbga_isqrt, tbga_div.
module tbga_lane (
	input logic clk,
	input logic en,
	input logic signed [tbga_pkg::POS_W-1:0] xa,
	input logic signed [tbga_pkg::POS_W-1:0] ya,
	input logic signed [tbga_pkg::POS_W-1:0] xb,
	input logic signed [tbga_pkg::POS_W-1:0] yb,
	input logic [tbga_pkg::GM_W-1:0] gm_a,
	input logic [tbga_pkg::GM_W-1:0] gm_b,
	output tbga_pkg::lane_t res
);
	localparam int DW = tbga_pkg::DIF_W;
	localparam int SQ = tbga_pkg::SQ_W;
	localparam int MD = tbga_pkg::MAG_DLY;
	localparam int ZD = tbga_pkg::ZERO_DLY;
	localparam int SD = tbga_pkg::SIGN_DLY;

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] mx, my;
	logic [DW-1:0] mx_s1, my_s1;
	logic nx_s1, ny_s1;

	assign dx = DW'(xb) - DW'(xa);
	assign dy = DW'(yb) - DW'(ya);
	assign mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign my = dy[DW-1] ? DW'(-dy) : DW'(dy);

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx;
			my_s1 <= my;
			nx_s1 <= dx[DW-1];
			ny_s1 <= dy[DW-1];
		end
	end

	logic [DW+SQ-1:0] sqx, sqy;

	tbga_mul #(.WA(DW)) u_sqx (.clk(clk), .en(en), .a(mx_s1), .b(SQ'(mx_s1)), .p(sqx));
	tbga_mul #(.WA(DW)) u_sqy (.clk(clk), .en(en), .a(my_s1), .b(SQ'(my_s1)), .p(sqy));

	logic [tbga_pkg::D2_W-1:0] d2_s2;
	logic [tbga_pkg::D2_W-1:0] d2_sum;

	assign d2_sum = tbga_pkg::D2_W'(sqx + sqy);

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s2 <= d2_sum;
		end
	end

	logic [SQ-1:0] root;
	logic [tbga_pkg::D2_W-1:0] d2_r;

	tbga_isqrt u_isqrt (.clk(clk), .en(en), .d2(d2_s2), .root(root), .d2_out(d2_r));

	// sideband delay lines
	logic [2*DW-1:0] mag_dl_q [0:MD-1];
	logic [1:0] sign_dl_q [0:SD-1];
	logic zero_dl_q [0:ZD-1];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_dl_q[0] <= {mx_s1, my_s1};
			sign_dl_q[0] <= {nx_s1, ny_s1};
			zero_dl_q[0] <= (d2_sum == '0);
			for (int i = 1; i < MD; i++) mag_dl_q[i] <= mag_dl_q[i-1];
			for (int i = 1; i < SD; i++) sign_dl_q[i] <= sign_dl_q[i-1];
			for (int i = 1; i < ZD; i++) zero_dl_q[i] <= zero_dl_q[i-1];
		end
	end

	logic [SQ-1:0] mx_d, my_d;

	assign mx_d = SQ'(mag_dl_q[MD-1][2*DW-1:DW]);
	assign my_d = SQ'(mag_dl_q[MD-1][DW-1:0]);

	logic [tbga_pkg::DEN_W-1:0] den;
	logic [tbga_pkg::NP_W-1:0] np_ax, np_ay, np_bx, np_by;

	tbga_mul #(.WA(tbga_pkg::D2_W)) u_den (.clk(clk), .en(en), .a(d2_r), .b(root), .p(den));
	tbga_mul #(.WA(tbga_pkg::GM_W)) u_nax (.clk(clk), .en(en), .a(gm_b), .b(mx_d), .p(np_ax));
	tbga_mul #(.WA(tbga_pkg::GM_W)) u_nay (.clk(clk), .en(en), .a(gm_b), .b(my_d), .p(np_ay));
	tbga_mul #(.WA(tbga_pkg::GM_W)) u_nbx (.clk(clk), .en(en), .a(gm_a), .b(mx_d), .p(np_bx));
	tbga_mul #(.WA(tbga_pkg::GM_W)) u_nby (.clk(clk), .en(en), .a(gm_a), .b(my_d), .p(np_by));

	tbga_div u_dax (.clk(clk), .en(en), .num_p(np_ax), .den(den), .q(res.a_x));
	tbga_div u_day (.clk(clk), .en(en), .num_p(np_ay), .den(den), .q(res.a_y));
	tbga_div u_dbx (.clk(clk), .en(en), .num_p(np_bx), .den(den), .q(res.b_x));
	tbga_div u_dby (.clk(clk), .en(en), .num_p(np_by), .den(den), .q(res.b_y));

	assign res.coincide = zero_dl_q[ZD-1];
	assign res.neg_x = sign_dl_q[SD-1][1];
	assign res.neg_y = sign_dl_q[SD-1][0];

endmodule

>>> rtl/tbga_checker.sv
// Port-level checks for three_body_gravity_acceleration, attached by bind.
// Depends on tbga_pkg (acc_t).
module tbga_checker (
	input logic clk,
	input logic arst_n,
	input logic pos_stall,
	input logic acc_valid,
	input logic acc_stall,
	input tbga_pkg::acc_t acc
);

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc_valid && acc_stall |=> acc_valid)
		else $error("result dropped while stalled");

	a_acc_stable: assert property (@(posedge clk) disable iff (!arst_n)
		acc_valid && acc_stall |=> $stable(acc))
		else $error("result changed while stalled");

	a_coincide_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc_valid && acc.coincide_error |->
			acc.acc_x_one == '0 && acc.acc_y_one == '0 &&
			acc.acc_x_two == '0 && acc.acc_y_two == '0 &&
			acc.acc_x_three == '0 && acc.acc_y_three == '0)
		else $error("nonzero acceleration with coincident bodies");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pos_stall |-> acc_valid && acc_stall)
		else $error("input stalled with no blocked result");

endmodule

bind three_body_gravity_acceleration tbga_checker u_tbga_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pos_stall(pos_stall),
	.acc_valid(acc_valid),
	.acc_stall(acc_stall),
	.acc(acc)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for three_body_gravity_acceleration: directed position sets,
// then random sets under several GM settings, checked against an in-bench predictor.
// Depends on tbga_pkg and the RTL under rtl/.
module testbench;

	localparam logic [tbga_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [tbga_pkg::GM_W-1:0] GM_MAX = '1;
	localparam int DRAIN_CYC = 130;

	typedef struct {
		tbga_pkg::pos_t p;
		bit typed;
		tbga_pkg::acc_t want;
	} vec_t;

	logic clk, arst_n;
	logic pos_valid, pos_stall, acc_valid, acc_stall;
	tbga_pkg::pos_t pos;
	tbga_pkg::acc_t acc;
	logic cfg_valid, cfg_ready;
	logic [tbga_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tbga_pkg::GM_W-1:0] cfg_data;

	logic [tbga_pkg::GM_W-1:0] gm_one, gm_two, gm_three;
	tbga_pkg::acc_t accel_q[$];
	int send_idle, recv_idle, hold_req;
	int mismatches, checked, coincide_seen, sent;

	three_body_gravity_acceleration DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [41:0] root(logic [81:0] d2);
		logic [41:0] r, t;
		logic [83:0] sq;
		r = '0;
		for (int b = 41; b >= 0; b--) begin
			t = r | (42'd1 << b);
			sq = {42'd0, t} * {42'd0, t};
			if (sq <= {2'b0, d2}) r = t;
		end
		return r;
	endfunction

	function automatic logic signed [50:0] pull(logic [tbga_pkg::GM_W-1:0] gm,
			logic signed [40:0] d, logic [81:0] d2, logic [41:0] s);
		logic [40:0] m;
		logic [179:0] num, den, q;
		if (d == 0 || gm == 0) return '0;
		m = d[40] ? -d : d;
		num = ({120'd0, gm} * {139'd0, m}) << tbga_pkg::NUM_SHIFT;
		den = {98'd0, d2} * {138'd0, s};
		q = num / den;
		if (q >= (180'd1 << 48)) q = 180'd1 << 48;
		return d[40] ? -$signed({2'b0, q[48:0]}) : $signed({2'b0, q[48:0]});
	endfunction

	function automatic logic [tbga_pkg::ACC_W-1:0] clamp_sum(logic signed [50:0] a,
			logic signed [50:0] b);
		logic signed [51:0] s;
		s = a + b;
		if (s > 52'sh7FFFFFFFFFFF) return 48'h7FFFFFFFFFFF;
		if (s < -52'sh800000000000) return 48'h800000000000;
		return s[47:0];
	endfunction

	function automatic logic [81:0] sqdist(logic signed [40:0] dx, logic signed [40:0] dy);
		logic [40:0] ax, ay;
		ax = dx[40] ? -dx : dx;
		ay = dy[40] ? -dy : dy;
		return {41'd0, ax} * {41'd0, ax} + {41'd0, ay} * {41'd0, ay};
	endfunction

	function automatic tbga_pkg::acc_t predict_accel(tbga_pkg::pos_t p);
		logic signed [40:0] x1, y1, x2, y2, x3, y3;
		logic [81:0] d12, d13, d23;
		logic [41:0] s12, s13, s23;
		tbga_pkg::acc_t a;
		x1 = p.pos_x_one; y1 = p.pos_y_one;
		x2 = p.pos_x_two; y2 = p.pos_y_two;
		x3 = p.pos_x_three; y3 = p.pos_y_three;
		d12 = sqdist(x2 - x1, y2 - y1);
		d13 = sqdist(x3 - x1, y3 - y1);
		d23 = sqdist(x3 - x2, y3 - y2);
		a = '0;
		if (d12 == 0 || d13 == 0 || d23 == 0) begin
			a.coincide_error = 1'b1;
			return a;
		end
		s12 = root(d12); s13 = root(d13); s23 = root(d23);
		a.acc_x_one = clamp_sum(pull(gm_two, x2 - x1, d12, s12), pull(gm_three, x3 - x1, d13, s13));
		a.acc_y_one = clamp_sum(pull(gm_two, y2 - y1, d12, s12), pull(gm_three, y3 - y1, d13, s13));
		a.acc_x_two = clamp_sum(pull(gm_one, x1 - x2, d12, s12), pull(gm_three, x3 - x2, d23, s23));
		a.acc_y_two = clamp_sum(pull(gm_one, y1 - y2, d12, s12), pull(gm_three, y3 - y2, d23, s23));
		a.acc_x_three = clamp_sum(pull(gm_one, x1 - x3, d13, s13), pull(gm_two, x2 - x3, d23, s23));
		a.acc_y_three = clamp_sum(pull(gm_one, y1 - y3, d13, s13), pull(gm_two, y2 - y3, d23, s23));
		return a;
	endfunction

	task automatic check_field(string name, logic [tbga_pkg::ACC_W-1:0] want,
			logic [tbga_pkg::ACC_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h got %h", name, want, got);
		end
	endtask

	// result side: compare and pick next stall
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (acc_valid && !acc_stall) begin
				tbga_pkg::acc_t want;
				if (accel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transfer on acc: %h", acc);
				end else begin
					want = accel_q.pop_front();
					checked++;
					if (want.coincide_error) coincide_seen++;
					check_field("acc_x_one", want.acc_x_one, acc.acc_x_one);
					check_field("acc_y_one", want.acc_y_one, acc.acc_y_one);
					check_field("acc_x_two", want.acc_x_two, acc.acc_x_two);
					check_field("acc_y_two", want.acc_y_two, acc.acc_y_two);
					check_field("acc_x_three", want.acc_x_three, acc.acc_x_three);
					check_field("acc_y_three", want.acc_y_three, acc.acc_y_three);
					check_field("coincide_error", 48'(want.coincide_error),
						48'(acc.coincide_error));
				end
			end
			if (hold_req != 0 && hold_left == 0) begin
				hold_left <= 400;
				hold_req = 0;
				acc_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				acc_stall <= 1'b1;
			end else begin
				acc_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	task automatic put(tbga_pkg::pos_t p, bit typed = 0, tbga_pkg::acc_t want = '0);
		pos_valid <= 1'b1;
		pos <= p;
		do @(posedge clk); while (pos_stall);
		accel_q.push_back(typed ? want : predict_accel(p));
		sent++;
		if ($urandom_range(99) < send_idle) begin
			pos_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		pos_valid <= 1'b0;
		while (accel_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [tbga_pkg::CFG_IDX_W-1:0] idx,
			logic [tbga_pkg::GM_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tbga_pkg::CFG_GM_ONE: gm_one = v;
			tbga_pkg::CFG_GM_TWO: gm_two = v;
			tbga_pkg::CFG_GM_THREE: gm_three = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [tbga_pkg::POS_W-1:0] coord();
		int w;
		logic [63:0] r;
		w = $urandom_range(1, tbga_pkg::POS_W);
		r = {$urandom, $urandom};
		if ($urandom_range(3) == 0) return r[tbga_pkg::POS_W-1:0];
		return tbga_pkg::POS_W'($signed(r[tbga_pkg::POS_W-1:0]) >>> (tbga_pkg::POS_W - w));
	endfunction

	function automatic tbga_pkg::pos_t rand_set();
		tbga_pkg::pos_t p;
		logic [tbga_pkg::POS_W-1:0] base;
		int k;
		k = $urandom_range(19);
		base = coord();
		p.pos_x_one = coord(); p.pos_y_one = coord();
		p.pos_x_two = coord(); p.pos_y_two = coord();
		p.pos_x_three = coord(); p.pos_y_three = coord();
		if (k < 8) begin
			// body two clustered around body one; body three takes the base x coordinate
			p.pos_x_two = p.pos_x_one +
				tbga_pkg::POS_W'($signed($urandom_range(0, 2000)) - 1000);
			p.pos_y_two = p.pos_y_one +
				tbga_pkg::POS_W'($signed($urandom_range(0, 2000)) - 1000);
			p.pos_x_three = base;
		end
		if (k == 19) begin
			p.pos_x_three = p.pos_x_two;
			p.pos_y_three = p.pos_y_two;
		end
		return p;
	endfunction

	localparam logic [tbga_pkg::POS_W-1:0] PMAX = {1'b0, {(tbga_pkg::POS_W-1){1'b1}}};
	localparam logic [tbga_pkg::POS_W-1:0] PMIN = {1'b1, {(tbga_pkg::POS_W-1){1'b0}}};
	vec_t directed[] = '{
		'{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 1}},
		'{'{5, 7, 5, 7, 1, 1}, 1, '{0, 0, 0, 0, 0, 0, 1}},
		'{'{PMAX, PMAX, PMIN, PMIN, PMAX, PMAX}, 1, '{0, 0, 0, 0, 0, 0, 1}},
		'{'{0, 0, 1, 0, 0, 1}, 0, '0},
		'{'{0, 0, -1, 0, 0, -1}, 0, '0},
		'{'{PMAX, PMAX, PMIN, PMIN, 0, 0}, 0, '0},
		'{'{PMIN, PMAX, PMAX, PMIN, 0, 1}, 0, '0},
		'{'{PMIN, 0, PMAX, 0, 0, PMAX}, 0, '0},
		'{'{0, 0, 40'sd149600000000, 0, 40'sd149600384400, 0}, 0, '0},
		'{'{0, 0, 3, 4, -3, -4}, 0, '0},
		'{'{100, -200, 100, 300, -400, -200}, 0, '0},
		'{'{-1, -1, 1, 1, 1, -1}, 0, '0},
		'{'{12345678, -87654321, -5, 99999, 0, 0}, 0, '0}
	};

	initial begin
		arst_n = 1'b0;
		pos_valid = 1'b0;
		pos = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle = 0; recv_idle = 0; hold_req = 0;
		mismatches = 0; checked = 0; coincide_seen = 0; sent = 0;
		gm_one = tbga_pkg::GM_ONE_RST;
		gm_two = tbga_pkg::GM_TWO_RST;
		gm_three = tbga_pkg::GM_THREE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) put(directed[i].p, directed[i].typed, directed[i].want);
		drain();
		write_reg(tbga_pkg::CFG_GM_ONE, GM_MAX);
		write_reg(tbga_pkg::CFG_GM_TWO, GM_MAX);
		write_reg(tbga_pkg::CFG_GM_THREE, GM_MAX);
		write_reg(CFG_UNUSED, 60'h123);
		foreach (directed[i]) put(directed[i].p, directed[i].typed, directed[i].want);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle = 28; recv_idle = 61;
					write_reg(tbga_pkg::CFG_GM_ONE, tbga_pkg::GM_ONE_RST);
					write_reg(tbga_pkg::CFG_GM_TWO, tbga_pkg::GM_TWO_RST);
					write_reg(tbga_pkg::CFG_GM_THREE, tbga_pkg::GM_THREE_RST);
				end
				1: begin
					send_idle = 61; recv_idle = 28;
					write_reg(tbga_pkg::CFG_GM_ONE, '0);
					write_reg(tbga_pkg::CFG_GM_TWO, tbga_pkg::GM_W'({$urandom, $urandom}));
					write_reg(tbga_pkg::CFG_GM_THREE, GM_MAX);
				end
				2: begin
					send_idle = 0; recv_idle = 0;
					write_reg(tbga_pkg::CFG_GM_ONE, tbga_pkg::GM_W'({$urandom, $urandom}));
					write_reg(tbga_pkg::CFG_GM_TWO,
						tbga_pkg::GM_W'({$urandom, $urandom} >> $urandom_range(63)));
					write_reg(tbga_pkg::CFG_GM_THREE, '0);
				end
				default: begin
					send_idle = 0; recv_idle = 0;
					write_reg(tbga_pkg::CFG_GM_ONE, tbga_pkg::GM_ONE_RST);
					write_reg(tbga_pkg::CFG_GM_TWO,
						tbga_pkg::GM_W'({$urandom, $urandom} >> $urandom_range(63)));
					write_reg(tbga_pkg::CFG_GM_THREE, tbga_pkg::GM_W'({$urandom, $urandom}));
					hold_req = 1;
				end
			endcase
			repeat (300) put(rand_set());
			drain();
		end

		$display("tb: %0d position sets sent, %0d results checked (%0d coincident), %0d mismatches",
			sent, checked, coincide_seen, mismatches);
		$display("tb: covered reset, zero, maximum and random GM settings with stalls on both sides");
		if (mismatches == 0 && accel_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
